### src/clsc_pkg.sv
package clsc_pkg;

    localparam int ADDR_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int HIST_LEN   = 5;
    localparam int OUT_DATA_W = 3 * ADDR_W;
    localparam int OUT_USER_W = 2;
    localparam int IN_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] PAD_BYTE       = 8'hCC;
    localparam logic [BYTE_W-1:0] RET_BYTE       = 8'hC3;
    localparam logic [BYTE_W-1:0] RETN_BYTE      = 8'hC2;
    localparam logic [BYTE_W-1:0] CALL_BYTE      = 8'hE8;
    localparam logic [BYTE_W-1:0] JMP_NEAR_BYTE  = 8'hE9;
    localparam logic [BYTE_W-1:0] JMP_SHORT_BYTE = 8'hEB;

    localparam logic [ADDR_W-1:0] OFFSET_MAX = '1;

    // configuration register indexes
    localparam logic CFG_CODE_BASE = 1'b0;
    localparam logic CFG_CODE_SIZE = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              section_end;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic              start_found;
        logic [ADDR_W-1:0] call_target_address;
        logic [ADDR_W-1:0] call_site_address;
        logic              call_found;
    } scan_res_t;

endpackage

### src/clsc_in_stage.sv
module clsc_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  clsc_pkg::in_item_t  s_item,
    input  logic                take,
    output logic                item_valid,
    output clsc_pkg::in_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    clsc_pkg::in_item_t item_reg;
    logic               load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/clsc_detect.sv
module clsc_detect
#(
    parameter int START_ALIGN_LOG2 = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [clsc_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              advance,
    input  clsc_pkg::in_item_t                item,
    output logic                              hit,
    output clsc_pkg::scan_res_t               res
);

    localparam logic [clsc_pkg::ADDR_W-1:0] ALIGN_MASK =
        clsc_pkg::ADDR_W'((64'd1 << START_ALIGN_LOG2) - 64'd1);

    logic [clsc_pkg::ADDR_W-1:0] code_base_reg;
    logic [clsc_pkg::ADDR_W-1:0] code_size_reg;
    logic [clsc_pkg::BYTE_W-1:0] hist_reg [clsc_pkg::HIST_LEN];
    logic [clsc_pkg::BYTE_W-1:0] hist_next [clsc_pkg::HIST_LEN];
    logic [clsc_pkg::ADDR_W-1:0] offset_reg;
    logic [clsc_pkg::ADDR_W-1:0] offset_next;
    logic                        pad_run_reg;
    logic                        pad_run_next;
    logic                        after_bnd_reg;
    logic                        after_bnd_next;

    logic [clsc_pkg::BYTE_W-1:0] cur;
    logic                        is_pad;
    logic [clsc_pkg::ADDR_W:0]   off_p1;
    logic [clsc_pkg::ADDR_W-1:0] disp;
    logic [clsc_pkg::ADDR_W-1:0] rel;
    logic                        call_shape;
    logic                        call_hit;
    logic                        boundary;
    logic [clsc_pkg::ADDR_W-1:0] start_addr;
    logic                        start_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_base_reg <= '0;
            code_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                clsc_pkg::CFG_CODE_BASE: code_base_reg <= cfg_data;
                clsc_pkg::CFG_CODE_SIZE: code_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cur    = item.code_byte;
    assign is_pad = (cur == clsc_pkg::PAD_BYTE);

    // call whose last displacement byte is the current one; opcode four back
    assign off_p1 = {1'b0, offset_reg} + 33'd1;
    assign disp   = {cur, hist_reg[0], hist_reg[1], hist_reg[2]};
    assign rel    = offset_reg + 32'd1 + disp;   // target - code_base

    assign call_shape = (offset_reg >= 32'd4) && (hist_reg[3] == clsc_pkg::CALL_BYTE)
                     && (off_p1 < {1'b0, code_size_reg});
    assign call_hit   = call_shape && (rel < code_size_reg);

    assign boundary = (offset_reg >= 32'd5) &&
                      ((hist_reg[0] == clsc_pkg::RET_BYTE) ||
                       (hist_reg[2] == clsc_pkg::RETN_BYTE) ||
                       (hist_reg[4] == clsc_pkg::JMP_NEAR_BYTE) ||
                       (hist_reg[1] == clsc_pkg::JMP_SHORT_BYTE));

    assign start_addr = code_base_reg + offset_reg;
    assign start_hit  = !is_pad && pad_run_reg && after_bnd_reg
                     && (offset_reg < code_size_reg)
                     && ((start_addr & ALIGN_MASK) == '0);

    always_comb
    begin
        res                     = '0;
        res.call_found          = call_hit;
        res.start_found         = start_hit;
        if (call_hit)
        begin
            res.call_site_address   = code_base_reg + offset_reg - 32'd4;
            res.call_target_address = code_base_reg + rel;
        end
        if (start_hit)
            res.start_address = start_addr;
        hit = call_hit || start_hit;
    end

    always_comb
    begin
        if (is_pad)
        begin
            pad_run_next   = 1'b1;
            after_bnd_next = pad_run_reg ? after_bnd_reg : boundary;
        end
        else
        begin
            pad_run_next   = 1'b0;
            after_bnd_next = 1'b0;
        end

        hist_next[0] = cur;
        for (int i = 1; i < clsc_pkg::HIST_LEN; i++)
            hist_next[i] = hist_reg[i-1];

        offset_next = (offset_reg == clsc_pkg::OFFSET_MAX) ? offset_reg
                                                           : offset_reg + 32'd1;

        // end of section: back to reset history
        if (item.section_end)
        begin
            pad_run_next   = 1'b0;
            after_bnd_next = 1'b0;
            offset_next    = '0;
            for (int i = 0; i < clsc_pkg::HIST_LEN; i++)
                hist_next[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            pad_run_reg   <= 1'b0;
            after_bnd_reg <= 1'b0;
            for (int i = 0; i < clsc_pkg::HIST_LEN; i++)
                hist_reg[i] <= '0;
        end
        else if (advance)
        begin
            offset_reg    <= offset_next;
            pad_run_reg   <= pad_run_next;
            after_bnd_reg <= after_bnd_next;
            for (int i = 0; i < clsc_pkg::HIST_LEN; i++)
                hist_reg[i] <= hist_next[i];
        end
    end

endmodule

### src/clsc_out_stage.sv
module clsc_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              hit,
    input  clsc_pkg::scan_res_t               res,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [clsc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [clsc_pkg::OUT_USER_W-1:0]   m_tuser
);

    logic                valid_reg;
    logic                valid_next;
    clsc_pkg::scan_res_t res_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && hit)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && hit)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.start_address, res_reg.call_target_address,
                       res_reg.call_site_address};
    assign m_tuser  = {res_reg.start_found, res_reg.call_found};

endmodule

### src/code_landmark_scanner_top.sv
// Each accepted byte is held in the input stage register; its result is loaded into the
// result register when the byte moves on, and m_tdata is driven from the result register.
// Throughput: one code byte per cycle; s_tready drops only while both registers hold an
// item and m_tready is low. Bytes that complete neither a call nor a start send nothing.
// Reset (rst_n low, asynchronous): both stages empty, history and offset zero,
// code_base and code_size zero.
module code_landmark_scanner_top
#(
    parameter int START_ALIGN_LOG2 = 4    // start alignment is 2**START_ALIGN_LOG2, 0..12
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [clsc_pkg::ADDR_W-1:0]       cfg_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [clsc_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] code_byte
    input  logic                              s_tlast,   // section_end

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] call_site_address, [63:32] call_target_address, [95:64] start_address
    output logic [clsc_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] call_found, [1] start_found
    output logic [clsc_pkg::OUT_USER_W-1:0]   m_tuser
);

    localparam logic [clsc_pkg::ADDR_W-1:0] ALIGN_MASK =
        clsc_pkg::ADDR_W'((64'd1 << START_ALIGN_LOG2) - 64'd1);

    clsc_pkg::in_item_t  s_item;
    clsc_pkg::in_item_t  item;
    clsc_pkg::scan_res_t res;
    logic                item_valid;
    logic                out_free;
    logic                advance;
    logic                hit;

    assign s_item.code_byte   = s_tdata;
    assign s_item.section_end = s_tlast;

    // the held byte moves on whenever the result register can take it
    assign advance = item_valid && out_free;

    clsc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    clsc_detect #(
        .START_ALIGN_LOG2 (START_ALIGN_LOG2)
    ) u_detect
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .hit       (hit),
        .res       (res)
    );

    clsc_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .hit      (hit),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_out_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || m_tuser[1]))
        else $error("result transfer with no flag set");

    a_no_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[95:64] == '0))
        else $error("start address nonzero without start flag");

    a_start_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata[95:64] & ALIGN_MASK) == '0))
        else $error("unaligned function start");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while result side is free");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int          ALIGN_LOG2   = 4;
    localparam logic [31:0] ALIGN        = 32'd1 << ALIGN_LOG2;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          SETTLE       = 4;       // pipeline is two stages deep
    localparam int          RANDOM_BYTES = 1000;
    localparam int          REPORT_MAX   = 10;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic                            cfg_index = clsc_pkg::CFG_CODE_BASE;
    logic [clsc_pkg::ADDR_W-1:0]     cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [clsc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [clsc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [clsc_pkg::OUT_USER_W-1:0] m_tuser;

    code_landmark_scanner_top #(.START_ALIGN_LOG2(ALIGN_LOG2)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scanner shadow: configuration and stream history
    logic [31:0] sec_base = '0;
    logic [31:0] sec_size = '0;
    logic [7:0]  recent [0:4] = '{default: 8'h00};   // newest first
    logic [31:0] byte_pos = '0;
    logic        pad_open = 1'b0;
    logic        pad_qualified = 1'b0;

    clsc_pkg::scan_res_t landmark_q [$];
    logic [7:0]          sec_body [$];

    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;
    int stall_left  = 0;
    int fail_cnt    = 0;
    int cycle_cnt   = 0;
    int bytes_sent  = 0;
    int random_bytes = 0;
    int results_seen = 0;
    int calls_seen  = 0;
    int starts_seen = 0;
    int phases_run  = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        sec_body = {sec_body, b};
    endfunction

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
            note_failure($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // work out what one accepted code byte produces
    task automatic track_byte(input logic [7:0] b, input logic last);
        clsc_pkg::scan_res_t hit;
        logic [31:0]         disp;
        logic [31:0]         tgt;
        logic [31:0]         addr;
        hit = '0;
        // call opcode four bytes back, this byte is the top of the displacement
        if (byte_pos >= 4 && recent[3] == clsc_pkg::CALL_BYTE
            && {1'b0, byte_pos} + 33'd1 < {1'b0, sec_size})
        begin
            disp = {b, recent[0], recent[1], recent[2]};
            tgt = sec_base + byte_pos + 32'd1 + disp;
            if (tgt - sec_base < sec_size)
            begin
                hit.call_found = 1'b1;
                hit.call_site_address = sec_base + byte_pos - 32'd4;
                hit.call_target_address = tgt;
            end
        end
        if (b == clsc_pkg::PAD_BYTE)
        begin
            if (!pad_open)
                pad_qualified = byte_pos >= 5 && (recent[0] == clsc_pkg::RET_BYTE
                    || recent[2] == clsc_pkg::RETN_BYTE
                    || recent[4] == clsc_pkg::JMP_NEAR_BYTE
                    || recent[1] == clsc_pkg::JMP_SHORT_BYTE);
            pad_open = 1'b1;
        end
        else
        begin
            addr = sec_base + byte_pos;
            if (pad_open && pad_qualified && byte_pos < sec_size && addr % ALIGN == 0)
            begin
                hit.start_found = 1'b1;
                hit.start_address = addr;
            end
            pad_open = 1'b0;
            pad_qualified = 1'b0;
        end
        recent[4] = recent[3];
        recent[3] = recent[2];
        recent[2] = recent[1];
        recent[1] = recent[0];
        recent[0] = b;
        if (byte_pos != clsc_pkg::OFFSET_MAX)
            byte_pos++;
        if (last)
        begin
            recent = '{default: 8'h00};
            byte_pos = '0;
            pad_open = 1'b0;
            pad_qualified = 1'b0;
        end
        if (hit.call_found || hit.start_found)
            landmark_q = {landmark_q, hit};
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == clsc_pkg::CFG_CODE_BASE)
            sec_base = val;
        else
            sec_size = val;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_section();
        int i;
        for (i = 0; i < sec_body.size(); i++)
            send_byte(sec_body[i], i == sec_body.size() - 1);
    endtask

    // let every expected result arrive, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (landmark_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mostly well-formed code: calls aimed into the section, returns and
    // jumps followed by padding that ends on an aligned byte, plus noise
    task automatic build_section(input int len);
        int          kind;
        int          n;
        int          i;
        logic [31:0] aim;
        logic [31:0] disp;
        logic [7:0]  b;
        sec_body.delete();
        while (sec_body.size() < len)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 22)
            begin
                if (sec_size != 0 && $urandom_range(0, 9) < 7)
                    aim = $urandom_range(0, sec_size - 1);
                else
                    aim = $urandom;
                disp = aim - sec_body.size() - 5;
                add_byte(clsc_pkg::CALL_BYTE);
                for (i = 0; i < 4; i++)
                    add_byte(disp[8*i +: 8]);
            end
            else if (kind < 50)
            begin
                case ($urandom_range(0, 3))
                    0: add_byte(clsc_pkg::RET_BYTE);
                    1: n = 2;
                    2: n = 4;
                    default: n = 1;
                endcase
                if (sec_body.size() == 0 || sec_body[$] != clsc_pkg::RET_BYTE)
                begin
                    add_byte(n == 2 ? clsc_pkg::RETN_BYTE
                           : n == 4 ? clsc_pkg::JMP_NEAR_BYTE : clsc_pkg::JMP_SHORT_BYTE);
                    repeat (n) add_byte(8'($urandom));
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    n = int'((32'd0 - (sec_base + sec_body.size())) & (ALIGN - 1));
                    if (n == 0)
                        n = ALIGN;
                end
                else
                    n = $urandom_range(1, 6);
                repeat (n) add_byte(clsc_pkg::PAD_BYTE);
                do
                    b = $urandom;
                while (b == clsc_pkg::PAD_BYTE);
                add_byte(b);
            end
            else
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
        end
    endtask

    // padding after each kind of boundary, base moved so each start is aligned
    task automatic test_pad_boundaries();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'hFFFF_FFF8);
        write_reg(clsc_pkg::CFG_CODE_SIZE, 32'hFFFF_FFFF);
        repeat (3) send_byte(8'h90, 1'b0);
        // call completes on the same byte that starts a function at address zero
        send_byte(clsc_pkg::JMP_SHORT_BYTE, 1'b0);
        send_byte(clsc_pkg::CALL_BYTE, 1'b0);
        repeat (3) send_byte(clsc_pkg::PAD_BYTE, 1'b0);
        send_byte(clsc_pkg::RET_BYTE, 1'b0);
        send_byte(clsc_pkg::PAD_BYTE, 1'b0);
        drain();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'hFFFF_FFF6);
        send_byte(clsc_pkg::RETN_BYTE, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(clsc_pkg::PAD_BYTE, 1'b0);
        drain();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'hFFFF_FFF2);
        send_byte(clsc_pkg::JMP_NEAR_BYTE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(clsc_pkg::PAD_BYTE, 1'b0);
        drain();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'hFFFF_FFEC);
        send_byte(clsc_pkg::JMP_SHORT_BYTE, 1'b0);
        send_byte(8'h05, 1'b0);
        repeat (2) send_byte(clsc_pkg::PAD_BYTE, 1'b0);
        // aligned, but just past the end of the section
        drain();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'h0000_0008);
        write_reg(clsc_pkg::CFG_CODE_SIZE, 32'd24);
        send_byte(8'h55, 1'b1);
        drain();
    endtask

    // backward call from the top of the address space lands outside the section, then a call in a section of size zero
    task automatic test_call_outside();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'hFFFF_FFFF);
        write_reg(clsc_pkg::CFG_CODE_SIZE, 32'd16);
        sec_body = '{clsc_pkg::CALL_BYTE, 8'hF6, 8'hFF, 8'hFF, 8'hFF};
        send_section();
        drain();
        write_reg(clsc_pkg::CFG_CODE_BASE, 32'h0000_0000);
        write_reg(clsc_pkg::CFG_CODE_SIZE, 32'h0000_0000);
        sec_body = '{8'h00, clsc_pkg::CALL_BYTE, 8'h00, 8'h00, 8'h00, 8'h00,
                     clsc_pkg::RET_BYTE};
        send_section();
    endtask

    task automatic test_random_sections();
        int          sel;
        logic [31:0] base_v;
        logic [31:0] size_v;
        while (random_bytes < RANDOM_BYTES)
        begin
            drain();
            sel = $urandom_range(0, 9);
            if (sel == 0)
                base_v = '0;
            else if (sel == 1)
                base_v = '1;
            else if (sel == 2)
                base_v = 32'hFFFF_FFFF - $urandom_range(0, 63);
            else if (sel < 6)
                base_v = {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'h0};
            else
                base_v = $urandom;
            sel = $urandom_range(0, 9);
            if (sel == 0)
                size_v = '0;
            else if (sel == 1)
                size_v = '1;
            else
                size_v = $urandom_range(8, 120);
            write_reg(clsc_pkg::CFG_CODE_BASE, base_v);
            write_reg(clsc_pkg::CFG_CODE_SIZE, size_v);
            src_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            phases_run++;
            repeat ($urandom_range(2, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                    build_section($urandom_range(1, 4));
                else
                    build_section($urandom_range(8, 90));
                send_section();
                random_bytes += sec_body.size();
            end
        end
    endtask

    // receiver backpressure
    always @(negedge clk)
    begin
        if (sink_stalls && stall_left == 0 && $urandom_range(0, 99) < 30)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        clsc_pkg::scan_res_t got;
        clsc_pkg::scan_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.call_found          = m_tuser[0];
            got.call_site_address   = m_tdata[31:0];
            got.call_target_address = m_tdata[63:32];
            got.start_found         = m_tuser[1];
            got.start_address       = m_tdata[95:64];
            results_seen++;
            if (got.call_found)
                calls_seen++;
            if (got.start_found)
                starts_seen++;
            if (landmark_q.size() == 0)
                note_failure($sformatf("unexpected transfer tuser %h tdata %h",
                                       m_tuser, m_tdata));
            else
            begin
                want = landmark_q.pop_front();
                compare_field("call_found", want.call_found, got.call_found);
                compare_field("call_site_address", want.call_site_address,
                              got.call_site_address);
                compare_field("call_target_address", want.call_target_address,
                              got.call_target_address);
                compare_field("start_found", want.start_found, got.start_found);
                compare_field("start_address", want.start_address, got.start_address);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, landmark_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_pad_boundaries();
        test_call_outside();
        test_random_sections();
        drain();
        if (landmark_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", landmark_q.size()));
        $display("scanned %0d bytes (%0d random over %0d configurations)",
                 bytes_sent, random_bytes, phases_run);
        $display("checked %0d results: %0d call sites, %0d function starts, %0d errors",
                 results_seen, calls_seen, starts_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### code_landmark_scanner_top.f
src/clsc_pkg.sv
src/clsc_in_stage.sv
src/clsc_detect.sv
src/clsc_out_stage.sv
src/code_landmark_scanner_top.sv
test/testbench.sv
